@@ rtl/spi_pkg.sv @@
package spi_pkg;

    // frame length limit: a bin whose index reaches this is the frame's last
    localparam int unsigned FFT_SIZE    = 2048;
    localparam int unsigned COUNTER_MAX = 2047;
    localparam int unsigned LAST_INDEX  = ((FFT_SIZE / 2) < COUNTER_MAX) ?
                                          (FFT_SIZE / 2) : COUNTER_MAX;

    localparam int unsigned MAG_W   = 16;
    localparam int unsigned PHASE_W = 16;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned OMAG_W  = 17;
    localparam int unsigned FREQ_W  = 19;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 56;

    // shared divider: remainder, divisor and quotient widths
    localparam int unsigned DIV_W     = 20;
    localparam int unsigned LOW_W     = 14;
    localparam int unsigned OFS_STEPS = 7;
    localparam int unsigned MAG_STEPS = 14;
    localparam int unsigned STEP_W    = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DIV_OFS,
        S_LOAD_MAG,
        S_DIV_MAG,
        S_EMIT_HELD,
        S_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

@@ rtl/spi_div.sv @@
// radix-2 restoring divider, one quotient bit per step
// remainder must start below the divisor; low bits are shifted in msb first
module spi_div (
    input  logic                           aclk,
    input  spi_pkg::div_ctrl_t             ctrl,
    input  logic [spi_pkg::DIV_W-1:0]      rem_init,
    input  logic [spi_pkg::LOW_W-1:0]      low_init,
    input  logic [spi_pkg::DIV_W-1:0]      divisor,
    output logic [spi_pkg::LOW_W-1:0]      quotient
);

    logic [spi_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [spi_pkg::LOW_W-1:0] low_reg, low_next;
    logic [spi_pkg::DIV_W-1:0] dvs_reg, dvs_next;
    logic [spi_pkg::LOW_W-1:0] quo_reg, quo_next;

    logic [spi_pkg::DIV_W:0]   shifted;
    logic [spi_pkg::DIV_W+1:0] trial;

    assign shifted = {rem_reg, low_reg[spi_pkg::LOW_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        rem_next = rem_reg;
        low_next = low_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        if (ctrl.load) begin
            rem_next = rem_init;
            low_next = low_init;
            dvs_next = divisor;
            quo_next = '0;
        end else if (ctrl.step) begin
            low_next = {low_reg[spi_pkg::LOW_W-2:0], 1'b0};
            if (!trial[spi_pkg::DIV_W+1]) begin
                rem_next = trial[spi_pkg::DIV_W-1:0];
                quo_next = {quo_reg[spi_pkg::LOW_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[spi_pkg::DIV_W-1:0];
                quo_next = {quo_reg[spi_pkg::LOW_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/spectral_peak_interpolator_top.sv @@
// channel  dir  beat contents
// s_       in   tdata: bin_magnitude[15:0], bin_phase[31:16]; tlast: last_bin
// m_       out  tdata: peak_magnitude[16:0], peak_phase[32:17],
//                      peak_frequency[51:33], zero[55:52]; tlast: frame_end
//
// the first bin of a frame only enters the window, other plain bins are taken
// and emitted; a peak: accept, square, 7 divider steps for the offset, load,
// 14 steps for the magnitude and emit; a bin closing the frame adds an emit
// reset is synchronous on aresetn low and empties the three-bin window
// input is taken only while the sequencer is idle; one output register
// holds a result until m_tready, and the sequencer waits on it when full
module spectral_peak_interpolator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spi_pkg::S_DATA_W-1:0]   s_tdata,   // bin_magnitude, bin_phase
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spi_pkg::M_DATA_W-1:0]   m_tdata,   // peak_magnitude, peak_phase,
                                                      // peak_frequency, zero pad
    output logic                           m_tlast
);

    localparam int unsigned MW = spi_pkg::MAG_W;
    localparam int unsigned CW = spi_pkg::CNT_W;

    spi_pkg::state_t state_reg, state_next;

    // three-bin window
    logic [MW-1:0]                 older_reg, older_next;
    logic [MW-1:0]                 held_reg, held_next;
    logic [spi_pkg::PHASE_W-1:0]   hphase_reg, hphase_next;
    logic [CW-1:0]                 counter_reg, counter_next;
    logic                          hvalid_reg, hvalid_next;

    // arriving bin
    logic [MW-1:0]                 cmag_reg;
    logic [spi_pkg::PHASE_W-1:0]   cphase_reg;
    logic                          clast_reg;
    logic                          peak_reg;

    // peak arithmetic
    logic [MW:0]                   den_reg;
    logic                          neg_reg;
    logic [2*MW-1:0]               sq_reg;
    logic [spi_pkg::OFS_STEPS-1:0] ofs_reg;
    logic [spi_pkg::STEP_W-1:0]    step_reg, step_next;

    // output register
    logic                          mvalid_reg, mvalid_next;
    logic [spi_pkg::M_DATA_W-1:0]  mdata_reg;
    logic                          mlast_reg;

    // sequencer outputs
    logic                          take_in;
    logic                          adv_in;
    logic                          adv_held;
    logic                          win_clear;
    logic                          arith_load;
    logic                          ofs_capture;
    logic                          out_load;
    logic                          out_sel_last;
    spi_pkg::div_ctrl_t            div_ctrl;

    logic [MW-1:0]                 in_mag;
    logic [spi_pkg::PHASE_W-1:0]   in_phase;
    logic                          peak_now;
    logic                          slot_free;
    logic [CW:0]                   idx_inc;
    logic [CW-1:0]                 next_idx;
    logic                          end_now;

    logic [MW+1:0]                 diff_w;
    logic [MW+1:0]                 den_w;
    logic [MW-1:0]                 abs_diff;

    logic [spi_pkg::DIV_W-1:0]     div_rem_init;
    logic [spi_pkg::LOW_W-1:0]     div_low_init;
    logic [spi_pkg::DIV_W-1:0]     div_divisor;
    logic [spi_pkg::LOW_W-1:0]     div_quo;

    logic [spi_pkg::FREQ_W-1:0]    base_freq;
    logic [spi_pkg::FREQ_W-1:0]    peak_freq;
    logic [spi_pkg::OMAG_W-1:0]    peak_mag;
    logic [spi_pkg::OMAG_W-1:0]    held_out_mag;
    logic [spi_pkg::FREQ_W-1:0]    held_out_freq;
    logic [spi_pkg::FREQ_W-1:0]    last_out_freq;
    logic [spi_pkg::M_DATA_W-1:0]  out_data;

    assign in_mag   = s_tdata[MW-1:0];
    assign in_phase = s_tdata[MW+spi_pkg::PHASE_W-1:MW];

    // strict local maximum of the held bin, with a left neighbour
    assign peak_now = hvalid_reg && (counter_reg != '0) &&
                      (held_reg > older_reg) && (held_reg > in_mag);

    assign slot_free = !mvalid_reg || m_tready;

    // index of the bin after the held one, clamped at the frame limit
    assign idx_inc  = {1'b0, counter_reg} + {{CW{1'b0}}, 1'b1};
    assign next_idx = !hvalid_reg ? '0 :
                      (idx_inc > (CW + 1)'(spi_pkg::LAST_INDEX)) ?
                      CW'(spi_pkg::LAST_INDEX) : idx_inc[CW-1:0];
    assign end_now  = clast_reg || (next_idx >= CW'(spi_pkg::LAST_INDEX));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spi_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (hvalid_reg) begin
                        state_next = peak_now ? spi_pkg::S_SQUARE : spi_pkg::S_EMIT_HELD;
                    end else if (s_tlast) begin
                        state_next = spi_pkg::S_EMIT_LAST;
                    end
                end
            end
            spi_pkg::S_SQUARE:   state_next = spi_pkg::S_DIV_OFS;
            spi_pkg::S_DIV_OFS: begin
                if (step_reg == spi_pkg::STEP_W'(spi_pkg::OFS_STEPS - 1)) begin
                    state_next = spi_pkg::S_LOAD_MAG;
                end
            end
            spi_pkg::S_LOAD_MAG: state_next = spi_pkg::S_DIV_MAG;
            spi_pkg::S_DIV_MAG: begin
                if (step_reg == spi_pkg::STEP_W'(spi_pkg::MAG_STEPS - 1)) begin
                    state_next = spi_pkg::S_EMIT_HELD;
                end
            end
            spi_pkg::S_EMIT_HELD: begin
                if (slot_free) begin
                    state_next = end_now ? spi_pkg::S_EMIT_LAST : spi_pkg::S_IDLE;
                end
            end
            spi_pkg::S_EMIT_LAST: begin
                if (slot_free) begin
                    state_next = spi_pkg::S_IDLE;
                end
            end
            default: state_next = spi_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        take_in       = 1'b0;
        adv_in        = 1'b0;
        adv_held      = 1'b0;
        win_clear     = 1'b0;
        arith_load    = 1'b0;
        ofs_capture   = 1'b0;
        out_load      = 1'b0;
        out_sel_last  = 1'b0;
        div_ctrl      = '{load: 1'b0, step: 1'b0};
        unique case (state_reg)
            spi_pkg::S_IDLE: begin
                s_tready = 1'b1;
                take_in  = s_tvalid;
                // first bin of a frame that is not also its last goes straight in
                adv_in   = s_tvalid && !hvalid_reg && !s_tlast;
            end
            spi_pkg::S_SQUARE: begin
                arith_load    = 1'b1;
                div_ctrl.load = 1'b1;
            end
            spi_pkg::S_DIV_OFS:  div_ctrl.step = 1'b1;
            spi_pkg::S_LOAD_MAG: begin
                ofs_capture   = 1'b1;
                div_ctrl.load = 1'b1;
            end
            spi_pkg::S_DIV_MAG:  div_ctrl.step = 1'b1;
            spi_pkg::S_EMIT_HELD: begin
                out_load = slot_free;
                adv_held = slot_free && !end_now;
            end
            spi_pkg::S_EMIT_LAST: begin
                out_load     = slot_free;
                out_sel_last = 1'b1;
                win_clear    = slot_free;
            end
            default: ;
        endcase
    end

    // window update
    always_comb begin
        older_next   = older_reg;
        held_next    = held_reg;
        hphase_next  = hphase_reg;
        counter_next = counter_reg;
        hvalid_next  = hvalid_reg;
        if (win_clear) begin
            older_next   = '0;
            held_next    = '0;
            hphase_next  = '0;
            counter_next = '0;
            hvalid_next  = 1'b0;
        end else if (adv_in) begin
            older_next   = '0;
            held_next    = in_mag;
            hphase_next  = in_phase;
            counter_next = '0;
            hvalid_next  = 1'b1;
        end else if (adv_held) begin
            older_next   = held_reg;
            held_next    = cmag_reg;
            hphase_next  = cphase_reg;
            counter_next = next_idx;
            hvalid_next  = 1'b1;
        end
    end

    // d = 2b - a - g and g - a, from the window's older and held bins and the arriving bin
    assign diff_w   = {2'b00, cmag_reg} - {2'b00, older_reg};
    assign den_w    = {1'b0, held_reg, 1'b0} - {2'b00, older_reg} - {2'b00, cmag_reg};
    assign abs_diff = diff_w[MW+1] ? MW'(-diff_w) : diff_w[MW-1:0];

    // offset: |g-a| * 128 / d, magnitude term: (g-a)^2 / (8d)
    assign div_rem_init = arith_load ? spi_pkg::DIV_W'(abs_diff) :
                                       spi_pkg::DIV_W'(sq_reg[2*MW-1:spi_pkg::LOW_W]);
    assign div_low_init = arith_load ? '0 : sq_reg[spi_pkg::LOW_W-1:0];
    assign div_divisor  = arith_load ? spi_pkg::DIV_W'(den_w[MW:0]) :
                                       spi_pkg::DIV_W'({den_reg, 3'b000});

    spi_div u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .quotient (div_quo)
    );

    always_comb begin
        step_next = step_reg;
        if (div_ctrl.load) begin
            step_next = '0;
        end else if (div_ctrl.step) begin
            step_next = step_reg + 1'b1;
        end
    end

    // result assembly
    assign base_freq     = {counter_reg, 8'h00};
    assign peak_freq     = neg_reg ? base_freq - spi_pkg::FREQ_W'(ofs_reg) :
                                     base_freq + spi_pkg::FREQ_W'(ofs_reg);
    assign peak_mag      = {1'b0, held_reg} + spi_pkg::OMAG_W'(div_quo);
    assign held_out_mag  = peak_reg ? peak_mag : {1'b0, held_reg};
    assign held_out_freq = peak_reg ? peak_freq : base_freq;
    assign last_out_freq = {next_idx, 8'h00};

    assign out_data = out_sel_last ?
        {4'h0, last_out_freq, cphase_reg, 1'b0, cmag_reg} :
        {4'h0, held_out_freq, hphase_reg, held_out_mag};

    assign mvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spi_pkg::S_IDLE;
            mvalid_reg  <= 1'b0;
            older_reg   <= '0;
            held_reg    <= '0;
            hphase_reg  <= '0;
            counter_reg <= '0;
            hvalid_reg  <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            mvalid_reg  <= mvalid_next;
            older_reg   <= older_next;
            held_reg    <= held_next;
            hphase_reg  <= hphase_next;
            counter_reg <= counter_next;
            hvalid_reg  <= hvalid_next;
            step_reg    <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take_in) begin
            cmag_reg   <= in_mag;
            cphase_reg <= in_phase;
            clast_reg  <= s_tlast;
            peak_reg   <= peak_now;
        end
        if (arith_load) begin
            den_reg <= den_w[MW:0];
            neg_reg <= diff_w[MW+1];
            sq_reg  <= abs_diff * abs_diff;
        end
        if (ofs_capture) begin
            ofs_reg <= div_quo[spi_pkg::OFS_STEPS-1:0];
        end
        if (out_load) begin
            mdata_reg <= out_data;
            mlast_reg <= out_sel_last;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

@@ rtl/spi_checker.sv @@
module spi_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spi_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                           m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the block is ready for a bin right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // the frame's last bin passes through on a whole bin index
    a_last_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[40:33] == 8'h00)
        else $error("last bin of frame carries a sub-bin offset");

    // the pad bits above the frequency stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:52] == 4'h0)
        else $error("pad bits of result beat not zero");

endmodule

bind spectral_peak_interpolator_top spi_checker u_spi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
